FILE: src/wpchs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpchs_pkg
// Types and fixed constants of the window peak and cell heat statistics block.
// ----------------------------------------------------------------------------
package wpchs_pkg;

    localparam int POP_W      = 13;
    localparam int SUM_W      = 40;
    localparam int FRAMES_W   = 32;
    localparam int OUT_HEAT_W = 32;
    localparam int GRID_W     = 7;
    localparam int QXY_W      = 6;
    localparam int CFG_IDX_W  = 2;

    localparam logic [GRID_W-1:0]    GRID_RESET      = 7'd64;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_CELL   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_QUERY  = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode            opcode;
        logic [POP_W-1:0]   population;
        logic               cell_alive;
        logic [QXY_W-1:0]   query_x;
        logic [QXY_W-1:0]   query_y;
    } t_in_data;

    typedef struct packed {
        logic [POP_W-1:0]      window_max;
        logic [SUM_W-1:0]      total_population;
        logic [FRAMES_W-1:0]   frames_recorded;
        logic [OUT_HEAT_W-1:0] heat_value;
        logic [OUT_HEAT_W-1:0] max_heat;
    } t_out_data;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [GRID_W-1:0]    value;
    } t_cfg_data;

endpackage

`default_nettype wire

FILE: src/wpchs_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpchs channel interfaces
// Valid/ready channels for input requests, results and register writes.
// ----------------------------------------------------------------------------
interface wpchs_in_if;
    logic                valid;
    logic                ready;
    wpchs_pkg::t_in_data data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface wpchs_out_if;
    logic                 valid;
    logic                 ready;
    wpchs_pkg::t_out_data data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface wpchs_cfg_if;
    logic                 valid;
    logic                 ready;
    wpchs_pkg::t_cfg_data data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/window_peak_and_cell_heat_stats.sv
`default_nettype none
// ----------------------------------------------------------------------------
// window_peak_and_cell_heat_stats
// Frame statistics engine: population history window with peak, saturating
// totals, per-cell heat counters with peak heat, heat queries and clear.
//
//   channel  dir  request
//   i_in     in   opcode, population, cell_alive, query_x, query_y
//   o_out    out  window_max, total_population, frames_recorded, heat_value,
//                 max_heat
//   i_cfg    in   register index, write data (grid_width, grid_height)
//
// Record: the history window is scanned, one history entry read and compared a cycle.
// Cell and query wait on the registered heat store read; off the grid no read is made.
// Clear: one heat store entry zeroed a cycle, over all MAX_WIDTH*MAX_HEIGHT entries.
// After reset a clearing pass over all MAX_WIDTH*MAX_HEIGHT entries runs with i_in low.
// A finished result waits in the output register while the next request is taken.
// Hold the following result, and i_in, until o_out drains that register.
// ----------------------------------------------------------------------------
module window_peak_and_cell_heat_stats #(
    parameter int HISTORY_DEPTH = 256,
    parameter int MAX_WIDTH     = 64,
    parameter int MAX_HEIGHT    = 64,
    parameter int HEAT_BITS     = 32
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    wpchs_in_if.sink     i_in,
    wpchs_out_if.source  o_out,
    wpchs_cfg_if.sink    i_cfg
);

    localparam int POP_W      = wpchs_pkg::POP_W;
    localparam int SUM_W      = wpchs_pkg::SUM_W;
    localparam int FRAMES_W   = wpchs_pkg::FRAMES_W;
    localparam int GRID_W     = wpchs_pkg::GRID_W;
    localparam int QXY_W      = wpchs_pkg::QXY_W;
    localparam int OUT_HEAT_W = wpchs_pkg::OUT_HEAT_W;

    localparam int HAW        = $clog2(HISTORY_DEPTH);
    localparam int CNTW       = $clog2(HISTORY_DEPTH + 1);
    localparam int HEAT_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW         = (HEAT_DEPTH > 1) ? $clog2(HEAT_DEPTH) : 1;
    localparam int CW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int MW1        = (CW > RW) ? CW : RW;
    localparam int MW2        = (MW1 > GRID_W) ? MW1 : GRID_W;
    localparam int MW3        = (MW2 > QXY_W) ? MW2 : QXY_W;
    localparam int CMPW       = MW3 + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_CELL,
        ST_QUERY,
        ST_FINISH
    } t_state;

    function automatic logic [AW-1:0] cell_index(input logic [RW-1:0] row,
                                                 input logic [CW-1:0] col);
        cell_index = AW'(row * MAX_WIDTH) + AW'(col);
    endfunction

    logic [POP_W-1:0]     mem_hist [HISTORY_DEPTH];
    logic [HEAT_BITS-1:0] mem_heat [HEAT_DEPTH];

    t_state                r_state,     n_state;
    logic [GRID_W-1:0]     r_grid_w,    n_grid_w;
    logic [GRID_W-1:0]     r_grid_h,    n_grid_h;
    logic [CNTW-1:0]       r_hist_cnt,  n_hist_cnt;
    logic [HAW-1:0]        r_hist_ptr,  n_hist_ptr;
    logic [POP_W-1:0]      r_peak_pop,  n_peak_pop;
    logic [SUM_W-1:0]      r_pop_sum,   n_pop_sum;
    logic [FRAMES_W-1:0]   r_frames,    n_frames;
    logic [HEAT_BITS-1:0]  r_peak_heat, n_peak_heat;
    logic [CW-1:0]         r_col,       n_col;
    logic [RW-1:0]         r_row,       n_row;
    logic [CNTW-1:0]       r_scan_idx,  n_scan_idx;
    logic                  r_scan_vld,  n_scan_vld;
    logic [POP_W-1:0]      r_scan_max,  n_scan_max;
    logic [AW-1:0]         r_clr_addr,  n_clr_addr;
    logic                  r_clr_reply, n_clr_reply;
    logic [AW-1:0]         r_cell_addr, n_cell_addr;
    logic                  r_alive,     n_alive;
    logic [HEAT_BITS-1:0]  r_heat,      n_heat;
    logic                  r_out_vld,   n_out_vld;
    wpchs_pkg::t_out_data  r_out,       n_out;

    logic [POP_W-1:0]      r_hist_q;
    logic [HEAT_BITS-1:0]  r_heat_q;

    logic                  hist_we;
    logic [HAW-1:0]        hist_waddr;
    logic [POP_W-1:0]      hist_wdata;
    logic                  hist_re;
    logic [HAW-1:0]        hist_raddr;
    logic                  heat_we;
    logic [AW-1:0]         heat_waddr;
    logic [HEAT_BITS-1:0]  heat_wdata;
    logic                  heat_re;
    logic [AW-1:0]         heat_raddr;

    logic [CMPW-1:0]       eff_w;
    logic [CMPW-1:0]       eff_h;
    logic [CMPW-1:0]       col_ext;
    logic [CMPW-1:0]       row_ext;
    logic [CMPW-1:0]       qx_ext;
    logic [CMPW-1:0]       qy_ext;
    logic [SUM_W:0]        sum_ext;
    logic [HEAT_BITS-1:0]  heat_new;
    logic                  in_fire;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;
    assign in_fire     = i_in.valid && (r_state == ST_IDLE);

    assign eff_w   = (CMPW'(r_grid_w) > CMPW'(MAX_WIDTH)) ? CMPW'(MAX_WIDTH)
                                                           : CMPW'(r_grid_w);
    assign eff_h   = (CMPW'(r_grid_h) > CMPW'(MAX_HEIGHT)) ? CMPW'(MAX_HEIGHT)
                                                            : CMPW'(r_grid_h);
    assign col_ext = CMPW'(r_col);
    assign row_ext = CMPW'(r_row);
    assign qx_ext  = CMPW'(i_in.data.query_x);
    assign qy_ext  = CMPW'(i_in.data.query_y);
    assign sum_ext = {1'b0, r_pop_sum} + (SUM_W + 1)'(i_in.data.population);
    assign heat_new = (r_alive && (r_heat_q != {HEAT_BITS{1'b1}}))
                    ? r_heat_q + HEAT_BITS'(1) : r_heat_q;

    always_comb begin
        n_state     = r_state;
        n_grid_w    = r_grid_w;
        n_grid_h    = r_grid_h;
        n_hist_cnt  = r_hist_cnt;
        n_hist_ptr  = r_hist_ptr;
        n_peak_pop  = r_peak_pop;
        n_pop_sum   = r_pop_sum;
        n_frames    = r_frames;
        n_peak_heat = r_peak_heat;
        n_col       = r_col;
        n_row       = r_row;
        n_scan_idx  = r_scan_idx;
        n_scan_vld  = r_scan_vld;
        n_scan_max  = r_scan_max;
        n_clr_addr  = r_clr_addr;
        n_clr_reply = r_clr_reply;
        n_cell_addr = r_cell_addr;
        n_alive     = r_alive;
        n_heat      = r_heat;
        n_out_vld   = r_out_vld && !o_out.ready;
        n_out       = r_out;

        hist_we    = 1'b0;
        hist_waddr = r_hist_ptr;
        hist_wdata = i_in.data.population;
        hist_re    = 1'b0;
        hist_raddr = r_scan_idx[HAW-1:0];
        heat_we    = 1'b0;
        heat_waddr = r_cell_addr;
        heat_wdata = heat_new;
        heat_re    = 1'b0;
        heat_raddr = cell_index(r_row, r_col);

        if (i_cfg.valid) begin
            if (i_cfg.data.index == wpchs_pkg::REG_GRID_WIDTH) begin
                n_grid_w = i_cfg.data.value;
            end
            if (i_cfg.data.index == wpchs_pkg::REG_GRID_HEIGHT) begin
                n_grid_h = i_cfg.data.value;
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_heat = '0;
                    unique case (i_in.data.opcode)
                        wpchs_pkg::OP_RECORD: begin
                            hist_we    = 1'b1;
                            n_hist_ptr = (r_hist_ptr == HAW'(HISTORY_DEPTH - 1))
                                       ? '0 : r_hist_ptr + HAW'(1);
                            if (r_hist_cnt != CNTW'(HISTORY_DEPTH)) begin
                                n_hist_cnt = r_hist_cnt + CNTW'(1);
                            end
                            n_pop_sum = sum_ext[SUM_W] ? {SUM_W{1'b1}}
                                                       : sum_ext[SUM_W-1:0];
                            if (r_frames != {FRAMES_W{1'b1}}) begin
                                n_frames = r_frames + FRAMES_W'(1);
                            end
                            n_col      = '0;
                            n_row      = '0;
                            n_scan_idx = '0;
                            n_scan_vld = 1'b0;
                            n_scan_max = '0;
                            n_state    = ST_SCAN;
                        end
                        wpchs_pkg::OP_CELL: begin
                            if ((eff_w == '0) || (eff_h == '0)) begin
                                n_col   = '0;
                                n_row   = '0;
                                n_state = ST_FINISH;
                            end else begin
                                if ((col_ext < eff_w) && (row_ext < eff_h)) begin
                                    heat_re     = 1'b1;
                                    n_cell_addr = cell_index(r_row, r_col);
                                    n_alive     = i_in.data.cell_alive;
                                    n_state     = ST_CELL;
                                end else begin
                                    n_state = ST_FINISH;
                                end
                                if (col_ext + CMPW'(1) >= eff_w) begin
                                    n_col = '0;
                                    n_row = (row_ext + CMPW'(1) >= eff_h)
                                          ? '0 : r_row + RW'(1);
                                end else begin
                                    n_col = r_col + CW'(1);
                                end
                            end
                        end
                        wpchs_pkg::OP_CLEAR: begin
                            n_hist_cnt  = '0;
                            n_hist_ptr  = '0;
                            n_peak_pop  = '0;
                            n_pop_sum   = '0;
                            n_frames    = '0;
                            n_peak_heat = '0;
                            n_col       = '0;
                            n_row       = '0;
                            n_clr_addr  = '0;
                            n_clr_reply = 1'b1;
                            n_state     = ST_CLEAR;
                        end
                        wpchs_pkg::OP_QUERY: begin
                            if ((qx_ext < eff_w) && (qy_ext < eff_h)) begin
                                heat_re    = 1'b1;
                                heat_raddr = cell_index(qy_ext[RW-1:0],
                                                        qx_ext[CW-1:0]);
                                n_state    = ST_QUERY;
                            end else begin
                                n_state = ST_FINISH;
                            end
                        end
                        default: begin
                            n_state = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                heat_we    = 1'b1;
                heat_waddr = r_clr_addr;
                heat_wdata = '0;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(HEAT_DEPTH - 1)) begin
                    n_clr_addr = '0;
                    n_state    = r_clr_reply ? ST_FINISH : ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (r_scan_vld && (r_hist_q > r_scan_max)) begin
                    n_scan_max = r_hist_q;
                end
                if (r_scan_idx < r_hist_cnt) begin
                    hist_re    = 1'b1;
                    n_scan_idx = r_scan_idx + CNTW'(1);
                    n_scan_vld = 1'b1;
                end else begin
                    n_scan_vld = 1'b0;
                    if (!r_scan_vld) begin
                        n_peak_pop = r_scan_max;
                        n_state    = ST_FINISH;
                    end
                end
            end
            ST_CELL: begin
                heat_we = 1'b1;
                n_heat  = heat_new;
                if (heat_new > r_peak_heat) begin
                    n_peak_heat = heat_new;
                end
                n_state = ST_FINISH;
            end
            ST_QUERY: begin
                n_heat  = r_heat_q;
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (!r_out_vld || o_out.ready) begin
                    n_out_vld                = 1'b1;
                    n_out.window_max         = r_peak_pop;
                    n_out.total_population   = r_pop_sum;
                    n_out.frames_recorded    = r_frames;
                    n_out.heat_value         = OUT_HEAT_W'(r_heat);
                    n_out.max_heat           = OUT_HEAT_W'(r_peak_heat);
                    n_state                  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_grid_w    <= wpchs_pkg::GRID_RESET;
            r_grid_h    <= wpchs_pkg::GRID_RESET;
            r_hist_cnt  <= '0;
            r_hist_ptr  <= '0;
            r_peak_pop  <= '0;
            r_pop_sum   <= '0;
            r_frames    <= '0;
            r_peak_heat <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_scan_vld  <= 1'b0;
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_grid_w    <= n_grid_w;
            r_grid_h    <= n_grid_h;
            r_hist_cnt  <= n_hist_cnt;
            r_hist_ptr  <= n_hist_ptr;
            r_peak_pop  <= n_peak_pop;
            r_pop_sum   <= n_pop_sum;
            r_frames    <= n_frames;
            r_peak_heat <= n_peak_heat;
            r_col       <= n_col;
            r_row       <= n_row;
            r_scan_vld  <= n_scan_vld;
            r_clr_addr  <= n_clr_addr;
            r_clr_reply <= n_clr_reply;
            r_out_vld   <= n_out_vld;
        end
        r_scan_idx  <= n_scan_idx;
        r_scan_max  <= n_scan_max;
        r_cell_addr <= n_cell_addr;
        r_alive     <= n_alive;
        r_heat      <= n_heat;
        r_out       <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            mem_hist[hist_waddr] <= hist_wdata;
        end
        if (hist_re) begin
            r_hist_q <= mem_hist[hist_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (heat_we) begin
            mem_heat[heat_waddr] <= heat_wdata;
        end
        if (heat_re) begin
            r_heat_q <= mem_heat[heat_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: test/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the window peak and cell heat statistics block.
// Requests come from a backlog through a clocked driver with random gaps.
// Each accepted request is run through a local model of the history window
// and the heat store, and every result is compared field by field. A directed
// opening is followed by randomised frames over many grid settings, including
// empty and clipped grids, a full history window and a long output hold-off.
// ----------------------------------------------------------------------------
module tb;

    localparam int HIST_DEPTH    = 256;
    localparam int GRID_MAX      = 64;
    localparam int CLEAR_BUDGET  = 11;
    localparam int RECORD_BUDGET = 520;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 90;
    localparam int WINDOW_FRAMES = 300;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    wpchs_in_if  req_ch ();
    wpchs_out_if res_ch ();
    wpchs_cfg_if cfg_ch ();

    window_peak_and_cell_heat_stats DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // statistics model
    logic [wpchs_pkg::GRID_W-1:0]     grid_cols;
    logic [wpchs_pkg::GRID_W-1:0]     grid_rows;
    logic [wpchs_pkg::POP_W-1:0]      win_ring [HIST_DEPTH];
    int                               win_fill;
    int                               win_wp;
    logic [wpchs_pkg::POP_W-1:0]      win_peak;
    logic [wpchs_pkg::SUM_W-1:0]      pop_total;
    logic [wpchs_pkg::FRAMES_W-1:0]   frame_cnt;
    logic [wpchs_pkg::OUT_HEAT_W-1:0] cell_heat [GRID_MAX*GRID_MAX];
    logic [wpchs_pkg::OUT_HEAT_W-1:0] heat_peak;
    int                               scan_col;
    int                               scan_row;

    wpchs_pkg::t_in_data  req_backlog [$];
    wpchs_pkg::t_out_data stats_due [$];

    int   queued_total    = 0;
    int   accepted_cnt    = 0;
    int   results_checked = 0;
    int   mismatches      = 0;
    int   phases_run      = 0;
    int   op_count [4]    = '{0, 0, 0, 0};
    int   clears_left     = CLEAR_BUDGET;
    int   records_left    = RECORD_BUDGET;
    int   idle_pct        = 0;
    int   send_gap        = 0;
    int   recv_stall      = 0;
    int   hold_left       = 0;
    logic hold_req        = 1'b0;
    logic hold_done       = 1'b0;

    function automatic int eff_dim(logic [wpchs_pkg::GRID_W-1:0] reg_val);
        return (reg_val < GRID_MAX) ? int'(reg_val) : GRID_MAX;
    endfunction

    function automatic void clear_stats();
        win_fill  = 0;
        win_wp    = 0;
        win_peak  = '0;
        pop_total = '0;
        frame_cnt = '0;
        heat_peak = '0;
        scan_col  = 0;
        scan_row  = 0;
        foreach (cell_heat[i]) cell_heat[i] = '0;
    endfunction

    function automatic wpchs_pkg::t_out_data next_stats(wpchs_pkg::t_in_data req);
        wpchs_pkg::t_out_data             res;
        logic [wpchs_pkg::OUT_HEAT_W-1:0] heat;
        logic [wpchs_pkg::SUM_W:0]        sum_wide;
        int                               cols;
        int                               rows;
        int                               slot;
        heat = '0;
        cols = eff_dim(grid_cols);
        rows = eff_dim(grid_rows);
        case (req.opcode)
            wpchs_pkg::OP_RECORD: begin
                win_ring[win_wp] = req.population;
                win_wp = (win_wp + 1) % HIST_DEPTH;
                if (win_fill < HIST_DEPTH) win_fill++;
                win_peak = '0;
                for (int i = 0; i < win_fill; i++) begin
                    if (win_ring[i] > win_peak) win_peak = win_ring[i];
                end
                sum_wide  = {1'b0, pop_total} + req.population;
                pop_total = sum_wide[wpchs_pkg::SUM_W] ? '1
                                                       : sum_wide[wpchs_pkg::SUM_W-1:0];
                if (frame_cnt != '1) frame_cnt++;
                scan_col = 0;
                scan_row = 0;
            end
            wpchs_pkg::OP_CELL: begin
                if (cols == 0 || rows == 0) begin
                    scan_col = 0;
                    scan_row = 0;
                end else begin
                    if (scan_col < cols && scan_row < rows) begin
                        slot = scan_row * GRID_MAX + scan_col;
                        if (req.cell_alive && cell_heat[slot] != '1) cell_heat[slot]++;
                        heat = cell_heat[slot];
                        if (heat > heat_peak) heat_peak = heat;
                    end
                    if (scan_col + 1 >= cols) begin
                        scan_col = 0;
                        scan_row = (scan_row + 1 >= rows) ? 0 : scan_row + 1;
                    end else begin
                        scan_col++;
                    end
                end
            end
            wpchs_pkg::OP_CLEAR: begin
                clear_stats();
            end
            wpchs_pkg::OP_QUERY: begin
                if (int'(req.query_x) < cols && int'(req.query_y) < rows) begin
                    heat = cell_heat[int'(req.query_y) * GRID_MAX + int'(req.query_x)];
                end
            end
        endcase
        res.window_max       = win_peak;
        res.total_population = pop_total;
        res.frames_recorded  = frame_cnt;
        res.heat_value       = heat;
        res.max_heat         = heat_peak;
        return res;
    endfunction

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= '0;
            send_gap     <= 0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                stats_due = {stats_due, next_stats(req_ch.data)};
                accepted_cnt <= accepted_cnt + 1;
                op_count[req_ch.data.opcode] <= op_count[req_ch.data.opcode] + 1;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (send_gap != 0) begin
                    send_gap     <= send_gap - 1;
                    req_ch.valid <= 1'b0;
                end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                    send_gap     <= $urandom_range(0, 11);
                    req_ch.valid <= 1'b0;
                end else if (req_backlog.size() != 0) begin
                    req_ch.valid <= 1'b1;
                    req_ch.data  <= req_backlog[0];
                    req_backlog.delete(0);
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long output hold-off
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_req && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result %0d: %s expected %0d, got %0d",
                         results_checked, name, want, got);
            end
        end
    endtask

    task automatic check_result(wpchs_pkg::t_out_data got);
        wpchs_pkg::t_out_data want;
        if (stats_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected result: max %0d total %0d frames %0d heat %0d peak %0d",
                         got.window_max, got.total_population, got.frames_recorded,
                         got.heat_value, got.max_heat);
            end
        end else begin
            want = stats_due[0];
            stats_due.delete(0);
            check_field("window_max", want.window_max, got.window_max);
            check_field("total_population", want.total_population, got.total_population);
            check_field("frames_recorded", want.frames_recorded, got.frames_recorded);
            check_field("heat_value", want.heat_value, got.heat_value);
            check_field("max_heat", want.max_heat, got.max_heat);
        end
        results_checked++;
    endtask

    // result monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
            recv_stall   <= 0;
        end else begin
            if (res_ch.valid && res_ch.ready) check_result(res_ch.data);
            if (hold_left != 0) begin
                res_ch.ready <= 1'b0;
            end else if (recv_stall != 0) begin
                recv_stall   <= recv_stall - 1;
                res_ch.ready <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                recv_stall   <= $urandom_range(0, 11);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    function automatic wpchs_pkg::t_in_data blank_request(wpchs_pkg::t_opcode op);
        wpchs_pkg::t_in_data req;
        logic [31:0]         noise;
        noise      = $urandom;
        req        = noise[$bits(wpchs_pkg::t_in_data)-1:0];
        req.opcode = op;
        return req;
    endfunction

    function automatic logic [wpchs_pkg::POP_W-1:0] random_pop();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return wpchs_pkg::POP_W'(4096);
            2:       return wpchs_pkg::POP_W'($urandom_range(4097, 8191));
            default: return wpchs_pkg::POP_W'($urandom_range(0, 4096));
        endcase
    endfunction

    function automatic void queue_query(int x, int y);
        wpchs_pkg::t_in_data req;
        req         = blank_request(wpchs_pkg::OP_QUERY);
        req.query_x = wpchs_pkg::QXY_W'(x);
        req.query_y = wpchs_pkg::QXY_W'(y);
        req_backlog = {req_backlog, req};
        queued_total++;
    endfunction

    function automatic void queue_record(logic [wpchs_pkg::POP_W-1:0] pop);
        wpchs_pkg::t_in_data req;
        if (records_left == 0) begin
            queue_query($urandom_range(0, 63), $urandom_range(0, 63));
        end else begin
            records_left--;
            req            = blank_request(wpchs_pkg::OP_RECORD);
            req.population = pop;
            req_backlog    = {req_backlog, req};
            queued_total++;
        end
    endfunction

    function automatic void queue_cell(logic alive);
        wpchs_pkg::t_in_data req;
        req            = blank_request(wpchs_pkg::OP_CELL);
        req.cell_alive = alive;
        req_backlog    = {req_backlog, req};
        queued_total++;
    endfunction

    function automatic void queue_clear();
        if (clears_left == 0) begin
            queue_query($urandom_range(0, 63), $urandom_range(0, 63));
        end else begin
            clears_left--;
            req_backlog = {req_backlog, blank_request(wpchs_pkg::OP_CLEAR)};
            queued_total++;
        end
    endfunction

    function automatic void queue_query_near();
        int cols;
        int rows;
        cols = eff_dim(grid_cols);
        rows = eff_dim(grid_rows);
        if ($urandom_range(0, 4) == 0) begin
            queue_query($urandom_range(0, 63), $urandom_range(0, 63));
        end else begin
            queue_query($urandom_range(0, (cols > 0) ? cols - 1 : 0),
                        $urandom_range(0, (rows > 0) ? rows - 1 : 0));
        end
    endfunction

    // raster frames with random content, plus some truncated frames and noise
    function automatic void queue_frames(int budget);
        int target;
        int span;
        int density;
        target = queued_total + budget;
        while (queued_total < target) begin
            if ($urandom_range(0, 99) < 6) begin
                case ($urandom_range(0, 3))
                    0:       queue_record(random_pop());
                    1:       queue_cell($urandom_range(0, 1));
                    2:       queue_clear();
                    default: queue_query($urandom_range(0, 63), $urandom_range(0, 63));
                endcase
            end else begin
                queue_record(random_pop());
                span = eff_dim(grid_cols) * eff_dim(grid_rows);
                if (span == 0) span = $urandom_range(2, 6);
                if ($urandom_range(0, 4) == 0) span = $urandom_range(0, span);
                density = $urandom_range(0, 100);
                for (int i = 0; i < span && queued_total < target; i++) begin
                    queue_cell($urandom_range(0, 99) < density);
                    if ($urandom_range(0, 99) < 8) queue_query_near();
                end
            end
        end
    endfunction

    task automatic wait_idle();
        do @(negedge clk);
        while (accepted_cnt != queued_total || stats_due.size() != 0);
    endtask

    task automatic write_reg(logic [wpchs_pkg::CFG_IDX_W-1:0] idx,
                             logic [wpchs_pkg::GRID_W-1:0] wdata);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{index: idx, value: wdata};
        do @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        if (idx == wpchs_pkg::REG_GRID_WIDTH) begin
            grid_cols = wdata;
        end else begin
            grid_rows = wdata;
        end
    endtask

    task automatic set_grid(logic [wpchs_pkg::GRID_W-1:0] cols,
                            logic [wpchs_pkg::GRID_W-1:0] rows);
        wait_idle();
        write_reg(wpchs_pkg::REG_GRID_WIDTH, cols);
        write_reg(wpchs_pkg::REG_GRID_HEIGHT, rows);
        @(negedge clk);
        phases_run++;
    endtask

    task automatic random_phase(logic [wpchs_pkg::GRID_W-1:0] cols,
                                logic [wpchs_pkg::GRID_W-1:0] rows, int pct);
        set_grid(cols, rows);
        idle_pct = pct;
        queue_frames(PHASE_ITEMS);
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        grid_cols    = wpchs_pkg::GRID_RESET;
        grid_rows    = wpchs_pkg::GRID_RESET;
        clear_stats();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // default grid: population extremes, first cells, corner queries, clear
        idle_pct = 10;
        queue_record(wpchs_pkg::POP_W'(0));
        queue_record(wpchs_pkg::POP_W'(8191));
        queue_record(wpchs_pkg::POP_W'(4096));
        queue_cell(1'b1);
        queue_cell(1'b1);
        queue_query(0, 0);
        queue_query(63, 63);
        queue_clear();
        queue_cell(1'b1);
        queue_query(0, 0);

        // two-cell grid: wrap past the last cell, queries off the grid
        set_grid(7'd2, 7'd1);
        queue_record(wpchs_pkg::POP_W'(4095));
        queue_cell(1'b1);
        queue_cell(1'b0);
        queue_cell(1'b1);
        queue_query(1, 0);
        queue_query(2, 0);
        queue_query(0, 1);

        // shrink under the scan position, then an empty grid
        set_grid(7'd1, 7'd1);
        queue_cell(1'b1);
        queue_cell(1'b1);
        set_grid(7'd0, 7'd1);
        queue_cell(1'b1);
        queue_query(0, 0);

        random_phase(7'd3, 7'd2, 20);
        random_phase(7'd8, 7'd8, 10);
        hold_req = 1'b1;
        random_phase(7'd0, 7'd4, 30);
        random_phase(7'd127, 7'd1, 0);
        random_phase(7'd1, 7'd127, 15);
        random_phase(7'd5, 7'd5, 40);

        // single cell grid: fill and wrap the history window
        set_grid(7'd1, 7'd1);
        idle_pct = 5;
        for (int f = 0; f < WINDOW_FRAMES; f++) begin
            queue_record(random_pop());
            if ($urandom_range(0, 1) == 1) queue_cell($urandom_range(0, 1));
            if ($urandom_range(0, 3) == 0) queue_query($urandom_range(0, 1), $urandom_range(0, 1));
        end

        random_phase(7'd64, 7'd64, 10);
        random_phase(7'd127, 7'd127, 20);
        random_phase(7'd4, 7'd0, 10);
        random_phase(wpchs_pkg::GRID_W'($urandom_range(1, 10)),
                     wpchs_pkg::GRID_W'($urandom_range(1, 10)), 25);
        random_phase(wpchs_pkg::GRID_W'($urandom_range(1, 10)),
                     wpchs_pkg::GRID_W'($urandom_range(1, 10)), 5);
        random_phase(7'd6, 7'd3, 0);

        wait_idle();
        repeat (300) @(posedge clk);
        @(negedge clk);
        $display("Checked %0d results over %0d grid settings, history window wrapped.",
                 results_checked, phases_run);
        $display("Requests: %0d record, %0d cell, %0d clear, %0d query.",
                 op_count[wpchs_pkg::OP_RECORD], op_count[wpchs_pkg::OP_CELL],
                 op_count[wpchs_pkg::OP_CLEAR], op_count[wpchs_pkg::OP_QUERY]);
        if (stats_due.size() != 0) $display("%0d results never arrived", stats_due.size());
        if (mismatches == 0 && stats_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("run timed out");
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

FILE: window_peak_and_cell_heat_stats.f
src/wpchs_pkg.sv
src/wpchs_if.sv
src/window_peak_and_cell_heat_stats.sv
test/tb.sv
